// ===== sv/counting_semaphore_fifo_waiters_defines.svh =====
// Assertion macros for the counting semaphore block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_DEFINES_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_DEFINES_SVH

`ifndef ASSERT_OFF
`define CSFW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("csfw assertion failed");
`define CSFW_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("csfw assertion failed");
`else
`define CSFW_ASSERT(label, clk, rst, prop)
`define CSFW_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== sv/csfw_pkg.sv =====
// Shared types and constants for the counting semaphore block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csfw_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 4;
  localparam int ADDR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEN_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 4;
  localparam int COUNT_W     = 9;
  localparam int INIT_W      = 8;
  localparam int COUNT_MAX   = 255;

  localparam logic [1:0] ACT_ACQUIRE = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CANCEL  = 2'd2;

  localparam logic REG_INITIAL_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic                 clear;
    logic                 push;
    logic                 remove;
    logic [ADDR_BITS-1:0] pos;
    logic [ID_BITS-1:0]   wid;
  } qcmd_t;

endpackage

`default_nettype wire

// ===== sv/counting_semaphore_fifo_waiters.sv =====
// Counting semaphore with a FIFO wait queue: acquire and release pass from IDLE
// to EXEC; cancel first passes SCAN (one queue slot compared per cycle by the
// single comparator), then EXEC. Next request is taken the cycle after the
// result is registered, so only one request is in flight at a time.
// Synchronous reset: count loads 1, initial_count 1, queue empty, no result held.
// Depends on csfw_pkg, csfw_waitq and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "counting_semaphore_fifo_waiters_defines.svh"

module counting_semaphore_fifo_waiters (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready,
  input  wire logic                                req_valid,
  output logic                                     req_ready,
  input  wire logic [1:0]                          action,
  input  wire logic [csfw_pkg::ID_W-1:0]           requester_id,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_ready,
  output logic                                     granted,
  output logic                                     blocked,
  output logic                                     woken_valid,
  output logic      [csfw_pkg::ID_W-1:0]           woken_id,
  output logic signed [csfw_pkg::COUNT_W-1:0]      count_after,
  output logic                                     error
);

  localparam int Depth    = csfw_pkg::QUEUE_DEPTH;
  localparam int IdBits   = csfw_pkg::ID_BITS;
  localparam int AddrBits = csfw_pkg::ADDR_BITS;
  localparam int LenBits  = csfw_pkg::LEN_BITS;
  localparam int IdW      = csfw_pkg::ID_W;
  localparam int CountW   = csfw_pkg::COUNT_W;
  localparam int InitW    = csfw_pkg::INIT_W;
  localparam logic signed [CountW:0] SumMax = (CountW+1)'(csfw_pkg::COUNT_MAX);

  csfw_pkg::state_t state, state_next;

  logic [InitW-1:0]         initial_count;
  logic signed [CountW-1:0] token_count, count_next;
  logic [1:0]               act;
  logic [IdBits-1:0]        id;
  logic [LenBits-1:0]       ptr;
  logic                     found;
  logic [AddrBits-1:0]      pos;

  logic [LenBits-1:0]       qlen;
  logic [IdBits-1:0]        head_id;
  logic [IdBits-1:0]        rd_id;
  csfw_pkg::qcmd_t          qcmd;

  logic cfg_wr;
  logic accept;
  logic out_free;
  logic scan_end;
  logic scan_hit;
  logic exec_fire;

  logic signed [CountW:0]   sum;
  logic                     res_granted, res_blocked, res_woken, res_error;
  logic [IdBits-1:0]        res_wid;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == csfw_pkg::REG_INITIAL_COUNT);
  assign prdata = (paddr[2] == csfw_pkg::REG_INITIAL_COUNT) ? 32'(initial_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= InitW'(1);
    end else if (cfg_wr) begin
      initial_count <= pwdata[InitW-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csfw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !rsp_valid || rsp_ready;
  assign accept   = req_valid && req_ready;
  assign scan_end = (ptr >= qlen);
  assign scan_hit = !scan_end && (rd_id == id);

  always_comb begin
    state_next = state;
    unique case (state)
      csfw_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (action == csfw_pkg::ACT_CANCEL) ? csfw_pkg::ST_SCAN
                                                        : csfw_pkg::ST_EXEC;
        end
      end
      csfw_pkg::ST_SCAN: begin
        if (scan_end || scan_hit) begin
          state_next = csfw_pkg::ST_EXEC;
        end
      end
      csfw_pkg::ST_EXEC: begin
        if (out_free) begin
          state_next = csfw_pkg::ST_IDLE;
        end
      end
      default: state_next = csfw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      csfw_pkg::ST_IDLE: req_ready = 1'b1;
      csfw_pkg::ST_SCAN: ;
      csfw_pkg::ST_EXEC: exec_fire = out_free;
      default: ;
    endcase
  end

  // item registers and scan pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= action;
      id    <= IdBits'(requester_id);
      ptr   <= '0;
      found <= 1'b0;
    end else if (state == csfw_pkg::ST_SCAN) begin
      if (scan_hit) begin
        found <= 1'b1;
        pos   <= ptr[AddrBits-1:0];
      end else if (!scan_end) begin
        ptr <= ptr + LenBits'(1);
      end
    end
  end

  csfw_waitq u_waitq (
    .clk     (clk),
    .rst     (rst),
    .cmd     (qcmd),
    .raddr   (ptr[AddrBits-1:0]),
    .qlen    (qlen),
    .head_id (head_id),
    .rd_id   (rd_id)
  );

  // shared count adder
  assign sum = $signed({token_count[CountW-1], token_count})
             + ((act == csfw_pkg::ACT_ACQUIRE) ? -(CountW+1)'(1) : (CountW+1)'(1));

  always_comb begin
    res_granted = 1'b0;
    res_blocked = 1'b0;
    res_woken   = 1'b0;
    res_error   = 1'b0;
    res_wid     = '0;
    count_next  = token_count;
    qcmd        = '0;
    qcmd.wid    = id;
    qcmd.pos    = pos;
    case (act) inside
      csfw_pkg::ACT_ACQUIRE: begin
        if (token_count[CountW-1] || token_count == '0) begin
          if (qlen == LenBits'(Depth)) begin
            res_error = 1'b1;
          end else begin
            count_next  = sum[CountW-1:0];
            qcmd.push   = 1'b1;
            res_blocked = 1'b1;
          end
        end else begin
          count_next  = sum[CountW-1:0];
          res_granted = 1'b1;
        end
      end
      csfw_pkg::ACT_RELEASE, csfw_pkg::ACT_CANCEL: begin
        if (act == csfw_pkg::ACT_CANCEL && found) begin
          qcmd.remove = 1'b1;
          count_next  = (sum > SumMax) ? CountW'(csfw_pkg::COUNT_MAX) : sum[CountW-1:0];
        end else if (sum > SumMax) begin
          res_error = 1'b1;
        end else begin
          count_next = sum[CountW-1:0];
          if ((sum[CountW] || sum == '0) && qlen != '0) begin
            res_woken   = 1'b1;
            res_wid     = head_id;
            qcmd.remove = 1'b1;
            qcmd.pos    = '0;
          end
        end
      end
      default: ;
    endcase
    if (!exec_fire) begin
      qcmd.push   = 1'b0;
      qcmd.remove = 1'b0;
    end
    qcmd.clear = cfg_wr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_count <= CountW'(1);
    end else if (cfg_wr) begin
      token_count <= CountW'(pwdata[InitW-1:0]);
    end else if (exec_fire) begin
      token_count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      granted     <= res_granted;
      blocked     <= res_blocked;
      woken_valid <= res_woken;
      woken_id    <= IdW'(res_wid);
      count_after <= count_next;
      error       <= res_error;
    end
  end

  `CSFW_ASSERT(a_qlen_bound, clk, rst, (qlen <= LenBits'(Depth)))
  `CSFW_ASSERT(a_one_outcome, clk, rst, rsp_valid |-> $onehot0({granted, blocked, woken_valid, error}))
  `CSFW_ASSERT(a_busy_after_accept, clk, rst, (req_valid && req_ready) |=> !req_ready)
  `CSFW_ASSERT(a_scan_in_range, clk, rst, (state == csfw_pkg::ST_SCAN) |-> (ptr <= qlen))
  `CSFW_ASSERT(a_blocked_negative, clk, rst, (rsp_valid && blocked) |-> count_after[CountW-1])

endmodule

`default_nettype wire

// ===== sv/csfw_waitq.sv =====
// Wait queue of requester IDs, oldest in slot 0, with push, remove-at and clear.
// Depends on csfw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csfw_waitq (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire csfw_pkg::qcmd_t                      cmd,
  input  wire logic [csfw_pkg::ADDR_BITS-1:0]       raddr,
  output logic      [csfw_pkg::LEN_BITS-1:0]        qlen,
  output logic      [csfw_pkg::ID_BITS-1:0]         head_id,
  output logic      [csfw_pkg::ID_BITS-1:0]         rd_id
);

  localparam int Depth    = csfw_pkg::QUEUE_DEPTH;
  localparam int IdBits   = csfw_pkg::ID_BITS;
  localparam int AddrBits = csfw_pkg::ADDR_BITS;
  localparam int LenBits  = csfw_pkg::LEN_BITS;

  logic [IdBits-1:0] ids [Depth];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ids[qlen[AddrBits-1:0]] <= cmd.wid;
    end else if (cmd.remove) begin
      for (int i = 0; i < Depth - 1; i++) begin
        if (AddrBits'(i) >= cmd.pos) begin
          ids[i] <= ids[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      qlen <= '0;
    end else if (cmd.push) begin
      qlen <= qlen + LenBits'(1);
    end else if (cmd.remove) begin
      qlen <= qlen - LenBits'(1);
    end
  end

  assign head_id = ids[0];
  assign rd_id   = ids[raddr];

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for counting_semaphore_fifo_waiters: directed and random traffic
// with an in-bench semaphore/wait-queue predictor and per-transfer result checks.
// Depends on csfw_pkg and the counting_semaphore_fifo_waiters RTL.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP = 10;

  typedef struct packed {
    logic                                granted;
    logic                                blocked;
    logic                                woken_valid;
    logic [csfw_pkg::ID_W-1:0]           woken_id;
    logic [csfw_pkg::COUNT_W-1:0]        count_after;
    logic                                error;
  } sem_result_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic req_valid, req_ready;
  logic [1:0] action;
  logic [csfw_pkg::ID_W-1:0] requester_id;
  logic rsp_valid, rsp_ready;
  logic granted, blocked, woken_valid, error;
  logic [csfw_pkg::ID_W-1:0] woken_id;
  logic signed [csfw_pkg::COUNT_W-1:0] count_after;

  // predictor state
  int sem_count;
  logic [csfw_pkg::ID_W-1:0] waiters[$];
  sem_result_t pending_results[$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  sem_result_t want;
  sem_result_t got;

  counting_semaphore_fifo_waiters u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready),
    .action(action), .requester_id(requester_id),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .granted(granted), .blocked(blocked), .woken_valid(woken_valid),
    .woken_id(woken_id), .count_after(count_after), .error(error)
  );

  always #5 clk = ~clk;

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic sem_result_t predict_op(logic [1:0] act,
                                             logic [csfw_pkg::ID_W-1:0] id);
    sem_result_t r;
    bit relay;
    int len;
    int pos;
    r = '0;
    relay = 1'b0;
    len = waiters.size();
    pos = -1;
    case (act)
      csfw_pkg::ACT_ACQUIRE: begin
        if (sem_count - 1 < 0) begin
          if (len >= csfw_pkg::QUEUE_DEPTH) begin
            r.error = 1'b1;
          end else begin
            sem_count = sem_count - 1;
            waiters.insert(waiters.size(), id);
            r.blocked = 1'b1;
          end
        end else begin
          sem_count = sem_count - 1;
          r.granted = 1'b1;
        end
      end
      csfw_pkg::ACT_RELEASE: relay = 1'b1;
      csfw_pkg::ACT_CANCEL: begin
        for (int i = 0; i < len && pos < 0; i++)
          if (waiters[i] == id) pos = i;
        if (pos >= 0) begin
          waiters.delete(pos);
          sem_count = (sem_count + 1 > csfw_pkg::COUNT_MAX) ? csfw_pkg::COUNT_MAX
                                                            : sem_count + 1;
        end else begin
          relay = 1'b1;
        end
      end
      default: ;
    endcase
    if (relay) begin
      if (sem_count + 1 > csfw_pkg::COUNT_MAX) begin
        r.error = 1'b1;
      end else begin
        sem_count = sem_count + 1;
        if (sem_count <= 0 && len > 0) begin
          r.woken_valid = 1'b1;
          r.woken_id = waiters[0];
          waiters.delete(0);
        end
      end
    end
    r.count_after = sem_count[csfw_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Call at a rising edge; leaves req_valid high after the transfer.
  task automatic send_op(logic [1:0] act, logic [csfw_pkg::ID_W-1:0] id);
    int gap;
    sem_result_t exp_r;
    gap = draw_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    action <= act;
    requester_id <= id;
    do @(posedge clk); while (!req_ready);
    exp_r = predict_op(act, id);
    pending_results.insert(pending_results.size(), exp_r);
  endtask

  task automatic set_initial_count(logic [7:0] value);
    req_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {csfw_pkg::REG_INITIAL_COUNT, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sem_count = int'(value);
    waiters.delete();
  endtask

  task automatic test_grant_block_wake();
    send_op(csfw_pkg::ACT_ACQUIRE, 4'd0);
    send_op(csfw_pkg::ACT_ACQUIRE, 4'd15);
    send_op(csfw_pkg::ACT_ACQUIRE, 4'd10);
    send_op(csfw_pkg::ACT_RELEASE, 4'd3);
    send_op(csfw_pkg::ACT_CANCEL, 4'd10);
    send_op(csfw_pkg::ACT_CANCEL, 4'd3);
    send_op(ACT_UNUSED, 4'd15);
  endtask

  task automatic test_queue_full();
    set_initial_count(8'd0);
    for (int i = 0; i <= csfw_pkg::QUEUE_DEPTH; i++)
      send_op(csfw_pkg::ACT_ACQUIRE, i[csfw_pkg::ID_W-1:0]);
  endtask

  task automatic test_duplicate_cancel();
    set_initial_count(8'd0);
    send_op(csfw_pkg::ACT_ACQUIRE, 4'd7);
    send_op(csfw_pkg::ACT_ACQUIRE, 4'd2);
    send_op(csfw_pkg::ACT_ACQUIRE, 4'd7);
    send_op(csfw_pkg::ACT_CANCEL, 4'd7);
    send_op(csfw_pkg::ACT_RELEASE, 4'd0);
  endtask

  task automatic test_count_overflow();
    set_initial_count(8'd255);
    send_op(csfw_pkg::ACT_RELEASE, 4'd0);
    send_op(csfw_pkg::ACT_CANCEL, 4'd9);
    send_op(csfw_pkg::ACT_ACQUIRE, 4'd4);
    send_op(csfw_pkg::ACT_RELEASE, 4'd4);
  endtask

  task automatic test_random_traffic();
    int init_vals[8];
    int acq_pct[8];
    int pick;
    logic [1:0] act;
    logic [csfw_pkg::ID_W-1:0] id;
    init_vals = '{1, 0, 255, 4, 0, 0, 2, 254};
    init_vals[4] = $urandom_range(0, 255);
    acq_pct = '{50, 60, 35, 55, 45, 70, 50, 40};
    for (int p = 0; p < 8; p++) begin
      set_initial_count(init_vals[p][7:0]);
      no_gaps = (p == 2 || p == 5);
      for (int n = 0; n < 150; n++) begin
        pick = $urandom_range(0, 99);
        id = $urandom_range(0, 1) ? csfw_pkg::ID_W'($urandom_range(0, 3))
                                  : csfw_pkg::ID_W'($urandom_range(0, 15));
        if (pick < acq_pct[p]) begin
          act = csfw_pkg::ACT_ACQUIRE;
        end else if (pick < acq_pct[p] + (95 - acq_pct[p]) / 2) begin
          act = csfw_pkg::ACT_RELEASE;
        end else if (pick < 95) begin
          act = csfw_pkg::ACT_CANCEL;
          if (waiters.size() > 0 && $urandom_range(0, 2) != 0)
            id = waiters[$urandom_range(0, waiters.size() - 1)];
        end else begin
          act = ACT_UNUSED;
        end
        send_op(act, id);
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic report_mismatch(string what, sem_result_t exp_r, sem_result_t act_r);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t mismatch (%s): exp g%0b b%0b w%0b id%0d cnt%0d e%0b, got g%0b b%0b w%0b id%0d cnt%0d e%0b",
               $realtime, what, exp_r.granted, exp_r.blocked, exp_r.woken_valid, exp_r.woken_id,
               $signed(exp_r.count_after), exp_r.error, act_r.granted, act_r.blocked,
               act_r.woken_valid, act_r.woken_id, $signed(act_r.count_after), act_r.error);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      got = '{granted, blocked, woken_valid, woken_id, count_after, error};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", '0, got);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.granted !== want.granted || got.blocked !== want.blocked ||
            got.woken_valid !== want.woken_valid || got.woken_id !== want.woken_id ||
            got.count_after !== want.count_after || got.error !== want.error)
          report_mismatch("field", want, got);
      end
    end
  end

  // result-side backpressure
  initial begin : rsp_side
    int gap;
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_valid <= 1'b0;
    action <= csfw_pkg::ACT_ACQUIRE;
    requester_id <= '0;
    rsp_ready <= 1'b0;
    sem_count = 1;
    waiters.delete();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_grant_block_wake();
    test_queue_full();
    test_duplicate_cancel();
    test_count_overflow();
    test_random_traffic();
    req_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
